// File: hw/rtl/psbs_pkg.sv
// ----------------------------------------------------------------------------
// psbs_pkg: shared types and constants of the particle steer/bounce step
// Operation and edge codes, register indexes, iterative unit request/response.
// ----------------------------------------------------------------------------
package psbs_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STEER  = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  localparam logic [1:0] EDGE_NONE  = 2'd0;
  localparam logic [1:0] EDGE_CLAMP = 2'd1;
  localparam logic [1:0] EDGE_WRAP  = 2'd2;

  localparam logic [2:0] REG_WIDTH     = 3'd0;
  localparam logic [2:0] REG_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_EDGE_MODE = 3'd2;
  localparam logic [2:0] REG_MAX_SPEED = 3'd3;
  localparam logic [2:0] REG_MAX_FORCE = 3'd4;

  localparam logic [14:0] WIDTH_RST     = 15'd1024;
  localparam logic [14:0] HEIGHT_RST    = 15'd768;
  localparam logic [1:0]  EDGE_MODE_RST = EDGE_CLAMP;
  localparam logic [30:0] MAX_SPEED_RST = 31'd157286;
  localparam logic [30:0] MAX_FORCE_RST = 31'd1966;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [63:0] opa;
    logic [31:0] opb;
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
    logic [31:0] rem;
  } unit_rsp_t;

  function automatic logic [31:0] sat33(input logic [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) r = v[32] ? S32_MIN : S32_MAX;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [32:0] mag33(input logic [32:0] v);
    logic [32:0] r;
    r = v[32] ? (33'd0 - v) : v;
    return r;
  endfunction

  function automatic logic [31:0] neg_sat(input logic [31:0] v);
    logic [31:0] r;
    r = (v == S32_MIN) ? S32_MAX : (32'd0 - v);
    return r;
  endfunction

endpackage

// File: hw/rtl/particle_steer_bounce_step.sv
// ----------------------------------------------------------------------------
// particle_steer_bounce_step: one 2-D particle with seek steering and edges
// Holds position, velocity and acceleration; loads, steers or updates them.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request: an operation
//   code plus target or load values and a gain. Output channel
//   (out_valid_o/out_ready_i) returns the full particle state after it.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i);
//   write it only while no request is in flight.
//   Load and unused codes go straight to the result step; update runs the
//   shared divider in wrap mode for each axis past a nonzero far edge; steer
//   runs two square roots and up to four divides on the shared iterative
//   unit, plus multiplies on one shared 32x32 multiplier (a zero target
//   offset skips the first two divides). The unit takes one step per cycle.
//   One request is in work at a time.
//   The result sits in its own output register, so a new request is taken
//   while the previous result still waits; a stalled receiver holds the
//   finished state in the done step until the output register frees.
//   Reset clears the particle state to zero and loads register defaults
//   (1024 x 768 field, clamp mode, speed 2.4, force 0.03).
// ----------------------------------------------------------------------------
module particle_steer_bounce_step #(
  parameter int unsigned FRAC_BITS = psbs_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] x_in_i,
  input  logic signed [31:0] y_in_i,
  input  logic signed [31:0] vx_in_i,
  input  logic signed [31:0] vy_in_i,
  input  logic signed [7:0]  attract_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] acc_x_o,
  output logic signed [31:0] acc_y_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_OFS, ST_SQ, ST_ROOT, ST_ROOTW, ST_DIVW, ST_FMUL, ST_FDIV,
    ST_GAIN, ST_SPEED, ST_DES, ST_SMAG, ST_VEL, ST_POS, ST_EDGE, ST_MODW,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [14:0] width_q, height_q;
  logic [1:0]  edge_mode_q;
  logic [30:0] max_speed_q, max_force_q;

  // particle and work registers
  logic [31:0] pos_q [2];
  logic [31:0] vel_q [2];
  logic [31:0] accel_q [2];
  logic [31:0] tgt_q [2];
  logic [31:0] mag_q [2];
  logic [31:0] val_q [2];
  logic [32:0] sfull_q [2];
  logic [1:0]  neg_q;
  logic [7:0]  ga_q;
  logic        att_neg_q, shift_q, axis_q, phase_q;
  logic [31:0] root_q;
  logic [63:0] sum_q, prod_q;
  logic        out_valid_q;

  psbs_pkg::unit_req_t req;
  psbs_pkg::unit_rsp_t rsp;

  psbs_iter_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // shared multiplier operands
  logic [31:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ: begin
        mul_a = mag_q[axis_q];
        mul_b = mag_q[axis_q];
      end
      ST_FMUL: begin
        mul_a = mag_q[axis_q];
        mul_b = {1'b0, max_force_q};
      end
      ST_GAIN: begin
        mul_a = {24'd0, ga_q};
        mul_b = val_q[axis_q];
      end
      ST_SPEED: begin
        mul_a = prod_q[31:0];
        mul_b = {1'b0, max_speed_q};
      end
      default: ;
    endcase
  end

  // offset and steer magnitudes with halving
  logic [32:0] d0, d1, dm0, dm1, sm0, sm1;
  logic        dfit, sfit;
  always_comb begin
    d0   = {tgt_q[0][31], tgt_q[0]} - {pos_q[0][31], pos_q[0]};
    d1   = {tgt_q[1][31], tgt_q[1]} - {pos_q[1][31], pos_q[1]};
    dm0  = psbs_pkg::mag33(d0);
    dm1  = psbs_pkg::mag33(d1);
    dfit = (dm0[32:31] != 2'd0) || (dm1[32:31] != 2'd0);
    sm0  = psbs_pkg::mag33(sfull_q[0]);
    sm1  = psbs_pkg::mag33(sfull_q[1]);
    sfit = (sm0[32:31] != 2'd0) || (sm1[32:31] != 2'd0);
  end

  // desired component from the scaled product
  logic [63:0] px;
  logic        des_neg;
  logic [31:0] des;
  logic [32:0] sdiff;
  always_comb begin
    px      = prod_q >> FRAC_BITS;
    des_neg = att_neg_q ^ neg_q[axis_q];
    if (px[63:31] != '0) des = des_neg ? psbs_pkg::S32_MIN : psbs_pkg::S32_MAX;
    else des = des_neg ? (32'd0 - px[31:0]) : px[31:0];
    sdiff = {des[31], des} - {vel_q[axis_q][31], vel_q[axis_q]};
  end

  // limit test on the steer length
  logic [32:0] m_cmp;
  logic        over;
  always_comb begin
    m_cmp = shift_q ? {rsp.result, 1'b0} : {1'b0, rsp.result};
    over  = m_cmp > {2'b0, max_force_q};
  end

  // edge handling of the selected axis
  logic [14:0] size_e;
  logic [31:0] p_e;
  logic [39:0] lim40;
  logic [31:0] lim_sat;
  logic        p_gt, p_lt;
  always_comb begin
    size_e  = axis_q ? height_q : width_q;
    p_e     = pos_q[axis_q];
    lim40   = 40'(size_e) << FRAC_BITS;
    lim_sat = (lim40 > 40'(psbs_pkg::S32_MAX)) ? psbs_pkg::S32_MAX : lim40[31:0];
    p_gt    = $signed({{8{p_e[31]}}, p_e}) > $signed(lim40);
    p_lt    = p_e[31];
  end

  // shared unit requests
  always_comb begin
    req = '0;
    case (state_q)
      ST_ROOT: begin
        req.start   = 1'b1;
        req.is_sqrt = 1'b1;
        req.opa     = sum_q + prod_q;
      end
      ST_ROOTW: begin
        if (rsp.done && !phase_q && rsp.result != '0) begin
          req.start = 1'b1;
          req.opa   = {32'd0, mag_q[0]} << FRAC_BITS;
          req.opb   = rsp.result;
        end
      end
      ST_DIVW: begin
        if (rsp.done && !phase_q && !axis_q) begin
          req.start = 1'b1;
          req.opa   = {32'd0, mag_q[1]} << FRAC_BITS;
          req.opb   = root_q;
        end
      end
      ST_FDIV: begin
        req.start = 1'b1;
        req.opa   = prod_q;
        req.opb   = root_q;
      end
      ST_EDGE: begin
        if (edge_mode_q == psbs_pkg::EDGE_WRAP && !p_lt && p_gt && size_e != '0) begin
          req.start = 1'b1;
          req.opa   = {32'd0, 32'(p_e >> FRAC_BITS)};
          req.opb   = {17'd0, size_e};
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= psbs_pkg::WIDTH_RST;
      height_q    <= psbs_pkg::HEIGHT_RST;
      edge_mode_q <= psbs_pkg::EDGE_MODE_RST;
      max_speed_q <= psbs_pkg::MAX_SPEED_RST;
      max_force_q <= psbs_pkg::MAX_FORCE_RST;
      pos_q       <= '{default: '0};
      vel_q       <= '{default: '0};
      accel_q     <= '{default: '0};
      out_valid_q <= 1'b0;
      axis_q      <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      prod_q <= 64'(mul_a * mul_b);
      if (out_valid_q && out_ready_i && state_q != ST_DONE) out_valid_q <= 1'b0;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          psbs_pkg::REG_WIDTH:     width_q     <= cfg_data_i[14:0];
          psbs_pkg::REG_HEIGHT:    height_q    <= cfg_data_i[14:0];
          psbs_pkg::REG_EDGE_MODE: edge_mode_q <= cfg_data_i[1:0];
          psbs_pkg::REG_MAX_SPEED: max_speed_q <= cfg_data_i;
          psbs_pkg::REG_MAX_FORCE: max_force_q <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            tgt_q[0]  <= x_in_i;
            tgt_q[1]  <= y_in_i;
            ga_q      <= attract_i[7] ? (8'd0 - attract_i) : attract_i;
            att_neg_q <= attract_i[7];
            axis_q    <= 1'b0;
            phase_q   <= 1'b0;
            case (operation_i)
              psbs_pkg::OP_LOAD: begin
                pos_q[0]   <= x_in_i;
                pos_q[1]   <= y_in_i;
                vel_q[0]   <= vx_in_i;
                vel_q[1]   <= vy_in_i;
                accel_q[0] <= '0;
                accel_q[1] <= '0;
                state_q    <= ST_DONE;
              end
              psbs_pkg::OP_STEER:  state_q <= ST_OFS;
              psbs_pkg::OP_UPDATE: state_q <= ST_VEL;
              default:             state_q <= ST_DONE;
            endcase
          end
        end
        // seek: offset to target, halved if too long
        ST_OFS: begin
          mag_q[0] <= dfit ? dm0[32:1] : dm0[31:0];
          mag_q[1] <= dfit ? dm1[32:1] : dm1[31:0];
          neg_q    <= {d1[32], d0[32]};
          state_q  <= ST_SQ;
        end
        // square each component, keep the first
        ST_SQ: begin
          sum_q <= prod_q;
          if (!axis_q) axis_q <= 1'b1;
          else state_q <= ST_ROOT;
        end
        ST_ROOT: state_q <= ST_ROOTW;
        ST_ROOTW: begin
          if (rsp.done) begin
            root_q <= rsp.result;
            axis_q <= 1'b0;
            if (!phase_q) begin
              if (rsp.result == '0) begin
                val_q[0] <= '0;
                val_q[1] <= '0;
                state_q  <= ST_GAIN;
              end else begin
                state_q <= ST_DIVW;
              end
            end else if (over) begin
              state_q <= ST_FMUL;
            end else begin
              accel_q[0] <= psbs_pkg::sat33(sfull_q[0]);
              accel_q[1] <= psbs_pkg::sat33(sfull_q[1]);
              state_q    <= ST_DONE;
            end
          end
        end
        ST_DIVW: begin
          if (rsp.done) begin
            if (!phase_q) begin
              val_q[axis_q] <= rsp.result;
              if (!axis_q) axis_q <= 1'b1;
              else begin
                axis_q  <= 1'b0;
                state_q <= ST_GAIN;
              end
            end else begin
              accel_q[axis_q] <= neg_q[axis_q] ? (32'd0 - rsp.result) : rsp.result;
              if (!axis_q) begin
                axis_q  <= 1'b1;
                state_q <= ST_FMUL;
              end else begin
                state_q <= ST_DONE;
              end
            end
          end
        end
        ST_FMUL:  state_q <= ST_FDIV;
        ST_FDIV:  state_q <= ST_DIVW;
        ST_GAIN:  state_q <= ST_SPEED;
        ST_SPEED: state_q <= ST_DES;
        // desired component, then steer = desired - velocity
        ST_DES: begin
          sfull_q[axis_q] <= sdiff;
          if (!axis_q) begin
            axis_q  <= 1'b1;
            state_q <= ST_GAIN;
          end else begin
            state_q <= ST_SMAG;
          end
        end
        ST_SMAG: begin
          mag_q[0] <= sfit ? sm0[32:1] : sm0[31:0];
          mag_q[1] <= sfit ? sm1[32:1] : sm1[31:0];
          neg_q    <= {sfull_q[1][32], sfull_q[0][32]};
          shift_q  <= sfit;
          phase_q  <= 1'b1;
          axis_q   <= 1'b0;
          state_q  <= ST_SQ;
        end
        // update: velocity first, then position
        ST_VEL: begin
          vel_q[0] <= psbs_pkg::sat33({vel_q[0][31], vel_q[0]} + {accel_q[0][31], accel_q[0]});
          vel_q[1] <= psbs_pkg::sat33({vel_q[1][31], vel_q[1]} + {accel_q[1][31], accel_q[1]});
          state_q  <= ST_POS;
        end
        ST_POS: begin
          pos_q[0] <= psbs_pkg::sat33({pos_q[0][31], pos_q[0]} + {vel_q[0][31], vel_q[0]});
          pos_q[1] <= psbs_pkg::sat33({pos_q[1][31], pos_q[1]} + {vel_q[1][31], vel_q[1]});
          axis_q   <= 1'b0;
          state_q  <= ST_EDGE;
        end
        ST_EDGE: begin
          if (edge_mode_q == psbs_pkg::EDGE_CLAMP && (p_gt || p_lt)) begin
            pos_q[axis_q] <= p_gt ? lim_sat : '0;
            vel_q[axis_q] <= psbs_pkg::neg_sat(vel_q[axis_q]);
          end else if (edge_mode_q == psbs_pkg::EDGE_WRAP && p_lt) begin
            pos_q[axis_q] <= lim_sat;
          end else if (edge_mode_q == psbs_pkg::EDGE_WRAP && p_gt && size_e == '0) begin
            pos_q[axis_q] <= '0;
          end
          if (edge_mode_q == psbs_pkg::EDGE_WRAP && !p_lt && p_gt && size_e != '0) begin
            state_q <= ST_MODW;
          end else if (!axis_q) begin
            axis_q <= 1'b1;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_MODW: begin
          if (rsp.done) begin
            pos_q[axis_q] <= rsp.rem << FRAC_BITS;
            if (!axis_q) begin
              axis_q  <= 1'b1;
              state_q <= ST_EDGE;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        // hold until the output register frees
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            pos_x_o     <= pos_q[0];
            pos_y_o     <= pos_q[1];
            vel_x_o     <= vel_q[0];
            vel_y_o     <= vel_q[1];
            acc_x_o     <= accel_q[0];
            acc_y_o     <= accel_q[1];
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/psbs_iter_unit.sv
// ----------------------------------------------------------------------------
// psbs_iter_unit: shared square root / divide unit
// One 65-bit subtract per cycle; 32 steps for either operation.
// ----------------------------------------------------------------------------
module psbs_iter_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psbs_pkg::unit_req_t req_i,
  output psbs_pkg::unit_rsp_t rsp_o
);

  logic        busy_q, done_q, sqrt_q;
  logic [4:0]  cnt_q;
  logic [63:0] n_q, r_q, bit_q;
  logic [31:0] d_q, res_q, rem_q;

  logic [32:0] t;
  logic [64:0] a, b, diff;
  logic        ge;
  logic [63:0] n_d, r_d;

  always_comb begin
    t = {n_q[63:32], n_q[31]};
    if (sqrt_q) begin
      a = {1'b0, n_q};
      b = {1'b0, r_q + bit_q};
    end else begin
      a = {32'd0, t};
      b = {33'd0, d_q};
    end
    diff = a - b;
    ge   = ~diff[64];
    if (sqrt_q) begin
      n_d = ge ? diff[63:0] : n_q;
      r_d = ge ? ((r_q >> 1) + bit_q) : (r_q >> 1);
    end else begin
      n_d = {(ge ? diff[31:0] : t[31:0]), n_q[30:0], ge};
      r_d = r_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sqrt_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        sqrt_q <= req_i.is_sqrt;
        cnt_q  <= '0;
        n_q    <= req_i.opa;
        r_q    <= '0;
        bit_q  <= 64'd1 << 62;
        d_q    <= req_i.opb;
      end else if (busy_q) begin
        n_q   <= n_d;
        r_q   <= r_d;
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          res_q  <= sqrt_q ? r_d[31:0] : n_d[31:0];
          rem_q  <= n_d[63:32];
        end
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;
  assign rsp_o.rem    = rem_q;

endmodule

// File: verif/particle_steer_bounce_step_tb.sv
// ----------------------------------------------------------------------------
// particle_steer_bounce_step_tb: self-checking bench of the particle step
// Drives load, steer, update and spare requests through the valid/ready channels,
// predicts the particle state after each request and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module particle_steer_bounce_step_tb;

  localparam int FRAC = 16;
  localparam logic [1:0] OP_SPARE = 2'd3;    // unused operation code
  localparam logic [1:0] EDGE_SPARE = 2'd3;  // unused edge mode
  localparam int STALL_LIMIT = 20000;
  localparam longint S32MAXL = 64'sd2147483647;
  localparam longint S32MINL = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
  } particle_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [30:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         operation_i = '0;
  logic signed [31:0] x_in_i = '0, y_in_i = '0, vx_in_i = '0, vy_in_i = '0;
  logic signed [7:0]  attract_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] pos_x_o, pos_y_o, vel_x_o, vel_y_o, acc_x_o, acc_y_o;

  particle_steer_bounce_step u_top (.*);

  always #5 clk_i = ~clk_i;

  // Shadow of the particle and of the registers
  longint          sh_px, sh_py, sh_vx, sh_vy, sh_ax, sh_ay;
  longint unsigned sh_width = 1024, sh_height = 768, sh_edge = 1;
  longint unsigned sh_speed = 157286, sh_force = 1966;

  particle_t state_q[$];   // expected particle states, oldest first
  int  fail_cnt = 0;
  int  tx_idle = 0, rx_idle = 0;
  int  rx_hold = 0;        // cycles the receiver must still hold off
  int  quiet_cycles = 0;

  function automatic longint sat32(longint v);
    if (v > S32MAXL) return S32MAXL;
    if (v < S32MINL) return S32MINL;
    return v;
  endfunction

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Seek force toward the target, limited to max_force
  function automatic void seek_force(longint tx, longint ty, longint att);
    longint dx, dy, dsx, dsy, stx, sty;
    longint unsigned ax, ay, ux, uy, len, ga, px, py, mx, my, m, rx, ry;
    bit nx, ny;
    int sh;
    dx = tx - sh_px;
    dy = ty - sh_py;
    ax = magn(dx);
    ay = magn(dy);
    ux = 0;
    uy = 0;
    ga = magn(att);
    if (ax >= 64'd1 << 31 || ay >= 64'd1 << 31) begin
      ax >>= 1;
      ay >>= 1;
    end
    len = int_sqrt(ax * ax + ay * ay);
    if (len != 0) begin
      ux = (ax << FRAC) / len;
      uy = (ay << FRAC) / len;
    end
    px = (ga * ux * sh_speed) >> FRAC;
    py = (ga * uy * sh_speed) >> FRAC;
    nx = (att < 0) != (dx < 0);
    ny = (att < 0) != (dy < 0);
    if (px > 64'd1 << 32) px = 64'd1 << 32;
    if (py > 64'd1 << 32) py = 64'd1 << 32;
    dsx = sat32(nx ? -longint'(px) : longint'(px));
    dsy = sat32(ny ? -longint'(py) : longint'(py));
    stx = dsx - sh_vx;
    sty = dsy - sh_vy;
    mx = magn(stx);
    my = magn(sty);
    sh = 0;
    if (mx >= 64'd1 << 31 || my >= 64'd1 << 31) begin
      mx >>= 1;
      my >>= 1;
      sh = 1;
    end
    m = int_sqrt(mx * mx + my * my);
    if ((m << sh) > sh_force) begin
      rx = mx * sh_force / m;
      ry = my * sh_force / m;
      sh_ax = stx < 0 ? -longint'(rx) : longint'(rx);
      sh_ay = sty < 0 ? -longint'(ry) : longint'(ry);
    end else begin
      sh_ax = sat32(stx);
      sh_ay = sat32(sty);
    end
  endfunction

  function automatic void edge_fix(ref longint p, ref longint v, input longint unsigned size);
    longint lim;
    longint unsigned ip;
    lim = longint'(size << FRAC);
    if (sh_edge == psbs_pkg::EDGE_CLAMP) begin
      if (p > lim) begin
        p = sat32(lim);
        v = sat32(-v);
      end else if (p < 0) begin
        p = 0;
        v = sat32(-v);
      end
    end else if (sh_edge == psbs_pkg::EDGE_WRAP) begin
      if (p < 0) p = sat32(lim);
      if (p > lim) begin
        ip = longint'(p) >> FRAC;
        p = size != 0 ? longint'((ip % size) << FRAC) : 0;
      end
    end
  endfunction

  // Advance the shadow particle by one request and return the new state
  function automatic particle_t next_particle(logic [1:0] op, logic signed [31:0] x,
                                              logic signed [31:0] y, logic signed [31:0] vx,
                                              logic signed [31:0] vy, logic signed [7:0] att);
    particle_t r;
    case (op)
      psbs_pkg::OP_LOAD: begin
        sh_px = longint'(x); sh_py = longint'(y);
        sh_vx = longint'(vx); sh_vy = longint'(vy);
        sh_ax = 0; sh_ay = 0;
      end
      psbs_pkg::OP_STEER: seek_force(longint'(x), longint'(y), longint'(att));
      psbs_pkg::OP_UPDATE: begin
        sh_vx = sat32(sh_vx + sh_ax);
        sh_vy = sat32(sh_vy + sh_ay);
        sh_px = sat32(sh_px + sh_vx);
        sh_py = sat32(sh_py + sh_vy);
        edge_fix(sh_px, sh_vx, sh_width);
        edge_fix(sh_py, sh_vy, sh_height);
      end
      default: ;
    endcase
    r.pos_x = sh_px[31:0]; r.pos_y = sh_py[31:0];
    r.vel_x = sh_vx[31:0]; r.vel_y = sh_vy[31:0];
    r.acc_x = sh_ax[31:0]; r.acc_y = sh_ay[31:0];
    return r;
  endfunction

  // Send one request; hold valid across back-to-back requests
  task automatic send_request(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] vx, logic signed [31:0] vy,
                              logic signed [7:0] att);
    while ($urandom_range(99) < tx_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    x_in_i <= x; y_in_i <= y; vx_in_i <= vx; vy_in_i <= vy; attract_i <= att;
    do @(posedge clk_i); while (!in_ready_o);
    state_q.push_back(next_particle(op, x, y, vx, vy, att));
    @(negedge clk_i);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Drain everything, let the block settle, then write one register
  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    drop_valid();
    wait (state_q.size() == 0);
    repeat (10) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      psbs_pkg::REG_WIDTH:     sh_width = 64'(val[14:0]);
      psbs_pkg::REG_HEIGHT:    sh_height = 64'(val[14:0]);
      psbs_pkg::REG_EDGE_MODE: sh_edge = 64'(val[1:0]);
      psbs_pkg::REG_MAX_SPEED: sh_speed = 64'(val);
      psbs_pkg::REG_MAX_FORCE: sh_force = 64'(val);
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] rand_q(longint unsigned span_px);
    // mostly on-field coordinates, sometimes anything at all
    if ($urandom_range(3) == 0) return $urandom;
    return $signed($urandom_range(0, 32'(span_px << FRAC))) - $signed(32'd4 << FRAC);
  endfunction

  function automatic logic signed [31:0] rand_vel();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, plus a long hold-off when asked
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle);
    end
  end

  // Checker: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    particle_t e;
    if (out_valid_o && out_ready_i) begin
      if (state_q.size() == 0) begin
        $error("result with no request outstanding");
        fail_cnt++;
      end else begin
        e = state_q.pop_front();
        if (pos_x_o !== e.pos_x) begin
          $error("pos_x exp %h got %h", e.pos_x, pos_x_o); fail_cnt++;
        end
        if (pos_y_o !== e.pos_y) begin
          $error("pos_y exp %h got %h", e.pos_y, pos_y_o); fail_cnt++;
        end
        if (vel_x_o !== e.vel_x) begin
          $error("vel_x exp %h got %h", e.vel_x, vel_x_o); fail_cnt++;
        end
        if (vel_y_o !== e.vel_y) begin
          $error("vel_y exp %h got %h", e.vel_y, vel_y_o); fail_cnt++;
        end
        if (acc_x_o !== e.acc_x) begin
          $error("acc_x exp %h got %h", e.acc_x, acc_x_o); fail_cnt++;
        end
        if (acc_y_o !== e.acc_y) begin
          $error("acc_y exp %h got %h", e.acc_y, acc_y_o); fail_cnt++;
        end
      end
    end
  end

  // Watchdog: count cycles with no traffic on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("particle_steer_bounce_step_tb: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed: load extremes, steer special cases, edges and spare codes
  task automatic test_directed();
    send_request(psbs_pkg::OP_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh7FFF_FFFF, 8'sd0);
    send_request(psbs_pkg::OP_UPDATE, 0, 0, 0, 0, 8'sd0);    // clamp both axes at zero
    send_request(psbs_pkg::OP_STEER, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0,
                 8'sh7F);                                   // huge offset
    send_request(psbs_pkg::OP_LOAD, 32'sh0010_0000, 32'sh0020_0000, 32'sh0001_0000,
                 -32'sh0002_0000, 8'sd0);
    send_request(psbs_pkg::OP_STEER, 32'sh0010_0000, 32'sh0020_0000, 0, 0,
                 8'sh05);                                   // zero offset
    send_request(psbs_pkg::OP_STEER, 32'sh0100_0000, 32'sh0000_0000, 0, 0,
                 8'sh80);                                   // repel
    send_request(psbs_pkg::OP_STEER, 32'sh0100_0000, 32'sh0100_0000, 0, 0, 8'sh00);
    send_request(psbs_pkg::OP_UPDATE, 0, 0, 0, 0, 8'sd0);
    send_request(OP_SPARE, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF,
                 8'shFF);
    write_reg(psbs_pkg::REG_MAX_SPEED, 31'h7FFF_FFFF);
    write_reg(psbs_pkg::REG_MAX_FORCE, 31'h7FFF_FFFF);
    send_request(psbs_pkg::OP_STEER, 32'sh7FFF_FFFF, 32'sh0000_0000, 0, 0,
                 8'sh7F);                                   // saturate desired
    send_request(psbs_pkg::OP_STEER, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 8'sh80);
    write_reg(psbs_pkg::REG_MAX_FORCE, 31'd0);
    send_request(psbs_pkg::OP_STEER, 32'sh0001_0000, 32'sh0000_0000, 0, 0, 8'sh01);
    write_reg(psbs_pkg::REG_EDGE_MODE, 31'(psbs_pkg::EDGE_WRAP));
    send_request(psbs_pkg::OP_LOAD, -32'sh0001_0000, 32'sh5000_0000, 0, 0, 8'sd0);
    send_request(psbs_pkg::OP_UPDATE, 0, 0, 0, 0, 8'sd0);    // wrap below and past
    write_reg(psbs_pkg::REG_WIDTH, 31'd0);
    write_reg(psbs_pkg::REG_HEIGHT, 31'h7FFF);
    send_request(psbs_pkg::OP_LOAD, 32'sh0123_4567, 32'sh7FFF_0000, 32'sh0001_0000,
                 32'sh0001_0000, 8'sd0);
    send_request(psbs_pkg::OP_UPDATE, 0, 0, 0, 0, 8'sd0);    // zero width in wrap
    write_reg(psbs_pkg::REG_EDGE_MODE, 31'(EDGE_SPARE));
    send_request(psbs_pkg::OP_LOAD, 32'sh7FFF_0000, -32'sh0001_0000, 32'sh7FFF_FFFF,
                 32'sh8000_0000, 8'sd0);
    send_request(psbs_pkg::OP_UPDATE, 0, 0, 0, 0, 8'sd0);
    write_reg(psbs_pkg::REG_EDGE_MODE, 31'(psbs_pkg::EDGE_NONE));
    send_request(psbs_pkg::OP_UPDATE, 0, 0, 0, 0, 8'sd0);
  endtask

  // Random register setting, extremes included
  task automatic random_config();
    int pick;
    pick = $urandom_range(4);
    write_reg(psbs_pkg::REG_WIDTH, pick == 0 ? 31'd1 : pick == 1 ? 31'h7FFF
                                             : 31'($urandom_range(1, 2000)));
    write_reg(psbs_pkg::REG_HEIGHT, pick == 0 ? 31'h7FFF : 31'($urandom_range(1, 2000)));
    write_reg(psbs_pkg::REG_EDGE_MODE, 31'($urandom_range(3)));
    write_reg(psbs_pkg::REG_MAX_SPEED, pick == 1 ? 31'd0 : pick == 2 ? 31'h7FFF_FFFF
                                       : 31'($urandom_range(0, 32'h0008_0000)));
    write_reg(psbs_pkg::REG_MAX_FORCE, pick == 3 ? 31'h7FFF_FFFF : pick == 4 ? 31'd0
                                       : 31'($urandom_range(0, 32'h0001_0000)));
  endtask

  // Random flights: a load, then steer/update runs with a little noise
  task automatic test_random_flights(int n_req);
    int sent;
    longint unsigned span;
    sent = 0;
    span = sh_width > sh_height ? sh_width : sh_height;
    if (span > 4000) span = 4000;
    while (sent < n_req) begin
      send_request(psbs_pkg::OP_LOAD, rand_q(span), rand_q(span), rand_vel(), rand_vel(),
                   8'($urandom));
      sent++;
      repeat ($urandom_range(4, 14)) begin
        case ($urandom_range(19))
          0: send_request(OP_SPARE, $urandom, $urandom, $urandom, $urandom, 8'($urandom));
          1, 2, 3, 4, 5, 6:
            send_request(psbs_pkg::OP_STEER, rand_q(span), rand_q(span), $urandom, $urandom,
                         8'($urandom));
          default: send_request(psbs_pkg::OP_UPDATE, $urandom, $urandom, $urandom, $urandom,
                                8'($urandom));
        endcase
        sent++;
      end
    end
  endtask

  // Hold the receiver off for a long stretch while requests keep coming
  task automatic test_backpressure();
    rx_hold = 600;
    repeat (8) send_request(psbs_pkg::OP_UPDATE, 0, 0, 0, 0, 8'sd0);
    send_request(psbs_pkg::OP_STEER, 32'sh0050_0000, 32'sh0030_0000, 0, 0, 8'sh03);
    repeat (4) send_request(psbs_pkg::OP_UPDATE, 0, 0, 0, 0, 8'sd0);
  endtask

  // Pause the sender until every result is back, then continue
  task automatic test_drain_pause();
    drop_valid();
    wait (state_q.size() == 0);
    send_request(psbs_pkg::OP_UPDATE, 0, 0, 0, 0, 8'sd0);
  endtask

  initial begin
    sh_px = 0; sh_py = 0; sh_vx = 0; sh_vy = 0; sh_ax = 0; sh_ay = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    tx_idle = 26; rx_idle = 71;
    random_config();
    test_random_flights(580);
    test_backpressure();
    tx_idle = 71; rx_idle = 26;
    random_config();
    test_random_flights(580);
    test_drain_pause();
    tx_idle = 0; rx_idle = 0;
    random_config();
    test_random_flights(580);
    test_backpressure();

    drop_valid();
    wait (state_q.size() == 0);
    repeat (300) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("particle_steer_bounce_step_tb: PASS");
    end else begin
      $display("particle_steer_bounce_step_tb: FAIL");
    end
    $finish;
  end

endmodule
